// ===== sv/sgsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_pkg
// Shared widths, register indexes and unit request types of the shear
// modulus preparation block.
// ----------------------------------------------------------------------------
package sgsm_pkg;

  localparam int VALUE_BITS      = 14;
  localparam int RATIO_FRAC_BITS = 40;
  localparam int RATIO_BITS      = 32;
  localparam int MOD_BITS        = 42;
  localparam int BUOY_BITS       = 32;
  localparam int WIDTH_REG_BITS  = 14;
  localparam int IDX_BITS        = 20;
  localparam int MAX_WIDTH_DEF   = 1024;

  // Shared multiplier: 44 x 44 bits as four 22 x 22 partial products.
  localparam int MUL_BITS  = 44;
  localparam int MUL_HALF  = MUL_BITS / 2;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // Shared divider: restoring, one quotient bit per cycle.
  localparam int DIV_REM_BITS = 44;
  localparam int DIV_LOW_BITS = 48;
  localparam int DIV_CNT_BITS = 6;

  localparam int BY_SHIFT = 56 - RATIO_FRAC_BITS;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH     = 2'd0,
    REG_STEP_RATIO     = 2'd1,
    REG_VELOCITY_LIMIT = 2'd2,
    REG_NONE           = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                start;
    logic [MUL_BITS-1:0] a;
    logic [MUL_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_REM_BITS-1:0] rem0;
    logic [DIV_LOW_BITS-1:0] low;
    logic [DIV_REM_BITS-1:0] den;
    logic [DIV_CNT_BITS-1:0] count;
  } div_req_t;

endpackage

// ===== sv/sgsm_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_sample_if
// Channel of grid samples into the block.
// ----------------------------------------------------------------------------
interface sgsm_sample_if;
  import sgsm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] shear_velocity;
  logic [VALUE_BITS-1:0] density;
  logic                  grid_end;

  modport source (output valid, shear_velocity, density, grid_end, input ready);
  modport sink   (input valid, shear_velocity, density, grid_end, output ready);
endinterface

// ===== sv/sgsm_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_result_if
// Channel of per-point results out of the block.
// ----------------------------------------------------------------------------
interface sgsm_result_if;
  import sgsm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BUOY_BITS-1:0] buoyancy;
  logic [MOD_BITS-1:0]  modulus_x;
  logic [MOD_BITS-1:0]  modulus_z;
  logic                 unstable;
  logic                 final_point;

  modport source (output valid, buoyancy, modulus_x, modulus_z, unstable, final_point,
                  input ready);
  modport sink   (input valid, buoyancy, modulus_x, modulus_z, unstable, final_point,
                  output ready);
endinterface

// ===== sv/sgsm_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_mul
// Shared 44 x 44 multiplier built from four registered 22 x 22 products.
// ----------------------------------------------------------------------------
module sgsm_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  sgsm_pkg::mul_req_t        req,
  output logic [sgsm_pkg::PROD_BITS-1:0] prod,
  output logic                      done
);
  import sgsm_pkg::*;

  logic                  active;
  logic [2:0]            step;
  logic [MUL_BITS-1:0]   a_r, b_r;
  logic [MUL_BITS-1:0]   pp;
  logic [1:0]            pp_sh;
  logic [PROD_BITS-1:0]  pp_shifted;
  logic [MUL_HALF-1:0]   a_part, b_part;

  assign a_part = step[1] ? a_r[MUL_BITS-1:MUL_HALF] : a_r[MUL_HALF-1:0];
  assign b_part = step[0] ? b_r[MUL_BITS-1:MUL_HALF] : b_r[MUL_HALF-1:0];

  always_comb begin
    unique case (pp_sh)
      2'd0:    pp_shifted = PROD_BITS'(pp);
      2'd1:    pp_shifted = PROD_BITS'(pp) << MUL_HALF;
      2'd2:    pp_shifted = PROD_BITS'(pp) << (2 * MUL_HALF);
      default: pp_shifted = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        step   <= '0;
        a_r    <= req.a;
        b_r    <= req.b;
        prod   <= '0;
      end else if (active) begin
        if (step != 3'd4) begin
          pp    <= a_part * b_part;
          pp_sh <= 2'(step[1]) + 2'(step[0]);
        end
        if (step != 3'd0) prod <= prod + pp_shifted;
        if (step == 3'd4) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end
endmodule

// ===== sv/sgsm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgsm_div
// Shared restoring divider, one quotient bit per cycle, with a preloaded
// partial remainder so short quotients need few iterations.
// ----------------------------------------------------------------------------
module sgsm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  sgsm_pkg::div_req_t               req,
  output logic [sgsm_pkg::DIV_LOW_BITS-1:0] quo,
  output logic [sgsm_pkg::DIV_REM_BITS-1:0] rem,
  output logic                             busy,
  output logic                             done
);
  import sgsm_pkg::*;

  logic [DIV_LOW_BITS-1:0] low;
  logic [DIV_REM_BITS-1:0] den;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_REM_BITS:0]   trial;
  logic [DIV_REM_BITS:0]   diff;
  logic                    ge;

  assign trial = {rem, low[DIV_LOW_BITS-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.rem0;
        low  <= req.low;
        den  <= req.den;
        cnt  <= req.count;
        quo  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[DIV_REM_BITS-1:0] : trial[DIV_REM_BITS-1:0];
        quo <= {quo[DIV_LOW_BITS-2:0], ge};
        low <= low << 1;
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== sv/staggered_grid_shear_modulus_prep_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_grid_shear_modulus_prep_unit
// Per-point buoyancy and harmonic-mean shear moduli for a staggered grid.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake        Beat contents
//   samples   in    valid/ready      shear_velocity, density, grid_end
//   results   out   valid/ready      buoyancy, modulus_x, modulus_z,
//                                    unstable, final_point
//   APB       in    psel/penable     grid_width, step_ratio, velocity_limit
//
// A sample beat forms its modulus in two passes on the shared multiplier.
// Each result then uses the shared divider for the column, for each
// harmonic mean and for the buoyancy quotient, and the multiplier for four
// passes. A zero-sum mean or a zero density skips its division. A point's
// result leaves on the next sample beat, and a grid-end beat yields two
// results if a point is held, else one. Reset is synchronous and clears
// the sequencer, the held point, the index and the velocity peak; the row
// line memory is not cleared. samples.ready is low from acceptance until
// the last result of that beat is taken, or until its modulus is formed
// if the beat yields none, and a stalled result holds its register.
//
module staggered_grid_shear_modulus_prep_unit #(
  parameter int MAX_WIDTH = sgsm_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  sgsm_sample_if.sink        samples,
  sgsm_result_if.source      results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sgsm_pkg::*;

  localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MV   = 13'b0000000000010,
    S_MD   = 13'b0000000000100,
    S_IDX  = 13'b0000000001000,
    S_IDXW = 13'b0000000010000,
    S_RD   = 13'b0000000100000,
    S_WR   = 13'b0000001000000,
    S_HM   = 13'b0000010000000,
    S_HD   = 13'b0000100000000,
    S_SC   = 13'b0001000000000,
    S_BY   = 13'b0010000000000,
    S_BYW  = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  // Configuration registers. The width register keeps 14 bits so that
  // oversize values clamp to the line depth instead of wrapping.
  logic [WIDTH_REG_BITS-1:0] grid_width;
  logic [RATIO_BITS-1:0]     step_ratio;
  logic [VALUE_BITS-1:0]     velocity_limit;
  reg_index_t                reg_sel;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= WIDTH_REG_BITS'(1);
      step_ratio     <= '0;
      velocity_limit <= '1;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_GRID_WIDTH:     grid_width     <= pwdata[WIDTH_REG_BITS-1:0];
        REG_STEP_RATIO:     step_ratio     <= pwdata;
        REG_VELOCITY_LIMIT: velocity_limit <= pwdata[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_GRID_WIDTH:     prdata = 32'(grid_width);
      REG_STEP_RATIO:     prdata = step_ratio;
      REG_VELOCITY_LIMIT: prdata = 32'(velocity_limit);
      default:            prdata = '0;
    endcase
  end

  // Effective row width: zero acts as one, oversize as the line depth.
  logic [WIDTH_REG_BITS-1:0] width_eff;
  always_comb begin
    priority if (grid_width == '0) width_eff = WIDTH_REG_BITS'(1);
    else if (grid_width > WIDTH_REG_BITS'(MAX_WIDTH)) width_eff = WIDTH_REG_BITS'(MAX_WIDTH);
    else width_eff = grid_width;
  end

  // Shared units.
  mul_req_t                mul_req;
  logic [PROD_BITS-1:0]    prod;
  logic                    mul_done;
  div_req_t                div_req;
  logic [DIV_LOW_BITS-1:0] div_quo;
  logic [DIV_REM_BITS-1:0] div_rem;
  logic                    div_busy;
  logic                    div_done;

  sgsm_mul u_mul (.clk, .rst, .req(mul_req), .prod, .done(mul_done));
  sgsm_div u_div (.clk, .rst, .req(div_req), .quo(div_quo), .rem(div_rem),
                  .busy(div_busy), .done(div_done));

  // Control state.
  state_t                state, state_next;
  logic                  held_valid;
  logic [IDX_BITS-1:0]   point_index;
  logic [VALUE_BITS-1:0] velocity_peak;
  logic                  side;

  // Payload registers.
  logic [VALUE_BITS-1:0] cur_density;
  logic                  cur_end;
  logic [MOD_BITS-1:0]   m_new;
  logic [MOD_BITS-1:0]   held_modulus;
  logic [VALUE_BITS-1:0] held_density;
  logic [MOD_BITS-1:0]   em_m, em_next, up_m;
  logic [VALUE_BITS-1:0] em_d;
  logic                  em_final;
  logic [COL_BITS-1:0]   col;
  logic                  up_ok;
  logic [MOD_BITS-1:0]   line_rd;
  logic [MOD_BITS-1:0]   mod_x, mod_z;
  logic [BUOY_BITS-1:0]  buoy;

  logic                  accept;
  logic                  out_take;
  logic [MOD_BITS-1:0]   partner;
  logic [MOD_BITS:0]     hsum;
  logic [PROD_BITS-1:0]  rounded;
  logic [MOD_BITS-1:0]   scaled;

  assign accept   = samples.valid && samples.ready;
  assign out_take = results.valid && results.ready;
  assign partner  = side ? up_m : em_next;
  assign hsum     = {1'b0, em_m} + {1'b0, partner};

  // Round half up at the ratio's binary point, then saturate to 42 bits.
  assign rounded = prod + (PROD_BITS'(1) << (RATIO_FRAC_BITS - 1));
  assign scaled  = (rounded[PROD_BITS-1:RATIO_FRAC_BITS+MOD_BITS] != '0) ? '1 :
                   rounded[RATIO_FRAC_BITS+MOD_BITS-1:RATIO_FRAC_BITS];

  // Row line of moduli, indexed by column.
  logic [MOD_BITS-1:0] line_mem [MAX_WIDTH];
  always_ff @(posedge clk) begin
    if (state == S_WR) line_mem[col] <= em_m;
    line_rd <= line_mem[col];
  end

  // Sequencer: issues unit requests and steps through one result at a time.
  always_comb begin
    state_next = state;
    mul_req    = '0;
    div_req    = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_BITS'(samples.shear_velocity);
          mul_req.b     = MUL_BITS'(samples.shear_velocity);
          state_next    = S_MV;
        end
      end
      S_MV: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_BITS'(prod[2*VALUE_BITS-1:0]);
          mul_req.b     = MUL_BITS'(cur_density);
          state_next    = S_MD;
        end
      end
      S_MD: begin
        if (mul_done) state_next = (held_valid || cur_end) ? S_IDX : S_IDLE;
      end
      S_IDX: begin
        div_req.start = 1'b1;
        div_req.rem0  = '0;
        div_req.low   = {point_index, {(DIV_LOW_BITS-IDX_BITS){1'b0}}};
        div_req.den   = DIV_REM_BITS'(width_eff);
        div_req.count = DIV_CNT_BITS'(IDX_BITS);
        state_next    = S_IDXW;
      end
      S_IDXW: begin
        if (div_done) state_next = S_RD;
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        mul_req.start = 1'b1;
        mul_req.a     = MUL_BITS'(em_m);
        mul_req.b     = MUL_BITS'(em_next);
        state_next    = S_HM;
      end
      S_HM: begin
        if (mul_done) begin
          if (hsum == '0) begin
            // A zero sum gives a zero mean; scaling zero keeps the flow uniform.
            mul_req.start = 1'b1;
            mul_req.a     = '0;
            mul_req.b     = MUL_BITS'(step_ratio);
            state_next    = S_SC;
          end else begin
            // The quotient fits in 44 bits, so the top of 2ab preloads the
            // remainder and only 44 iterations remain.
            div_req.start = 1'b1;
            div_req.rem0  = DIV_REM_BITS'(prod[2*MOD_BITS:MUL_BITS-1]);
            div_req.low   = {prod[MUL_BITS-2:0], {(DIV_LOW_BITS-MUL_BITS+1){1'b0}}};
            div_req.den   = DIV_REM_BITS'(hsum);
            div_req.count = DIV_CNT_BITS'(MUL_BITS);
            state_next    = S_HD;
          end
        end
      end
      S_HD: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = div_quo[MUL_BITS-1:0];
          mul_req.b     = MUL_BITS'(step_ratio);
          state_next    = S_SC;
        end
      end
      S_SC: begin
        if (mul_done) begin
          if (!side) begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_BITS'(em_m);
            mul_req.b     = MUL_BITS'(up_m);
            state_next    = S_HM;
          end else begin
            state_next = S_BY;
          end
        end
      end
      S_BY: begin
        if (em_d == '0) begin
          state_next = S_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.rem0  = '0;
          div_req.low   = {step_ratio, {BY_SHIFT{1'b0}}};
          div_req.den   = DIV_REM_BITS'(em_d);
          div_req.count = DIV_CNT_BITS'(DIV_LOW_BITS);
          state_next    = S_BYW;
        end
      end
      S_BYW: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_take) state_next = (!em_final && cur_end) ? S_IDX : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      held_valid    <= 1'b0;
      point_index   <= '0;
      velocity_peak <= '0;
      side          <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_density <= samples.density;
            cur_end     <= samples.grid_end;
            if (samples.shear_velocity > velocity_peak) velocity_peak <= samples.shear_velocity;
          end
        end
        S_MD: begin
          if (mul_done) begin
            m_new <= prod[MOD_BITS-1:0];
            priority if (held_valid) begin
              em_m     <= held_modulus;
              em_d     <= held_density;
              em_next  <= prod[MOD_BITS-1:0];
              em_final <= 1'b0;
            end else if (cur_end) begin
              em_m     <= prod[MOD_BITS-1:0];
              em_d     <= cur_density;
              em_next  <= prod[MOD_BITS-1:0];
              em_final <= 1'b1;
            end else begin
              held_modulus <= prod[MOD_BITS-1:0];
              held_density <= cur_density;
              held_valid   <= 1'b1;
            end
          end
        end
        S_IDXW: begin
          if (div_done) begin
            col   <= div_rem[COL_BITS-1:0];
            up_ok <= point_index >= IDX_BITS'(width_eff);
          end
        end
        S_WR: begin
          // Points in the first row pair with themselves for the row-up mean.
          up_m <= up_ok ? line_rd : em_m;
          side <= 1'b0;
        end
        S_SC: begin
          if (mul_done) begin
            if (!side) begin
              mod_x <= scaled;
              side  <= 1'b1;
            end else begin
              mod_z <= scaled;
            end
          end
        end
        S_BY: begin
          if (em_d == '0) buoy <= '1;
        end
        S_BYW: begin
          if (div_done) begin
            buoy <= (div_quo[DIV_LOW_BITS-1:BUOY_BITS] != '0) ? '1 : div_quo[BUOY_BITS-1:0];
          end
        end
        S_OUT: begin
          if (out_take) begin
            priority if (em_final) begin
              point_index   <= '0;
              held_valid    <= 1'b0;
              velocity_peak <= '0;
            end else if (cur_end) begin
              point_index <= point_index + IDX_BITS'(1);
              em_m        <= m_new;
              em_d        <= cur_density;
              em_next     <= m_new;
              em_final    <= 1'b1;
              held_valid  <= 1'b0;
            end else begin
              point_index  <= point_index + IDX_BITS'(1);
              held_modulus <= m_new;
              held_density <= cur_density;
              held_valid   <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign samples.ready       = (state == S_IDLE);
  assign results.valid       = (state == S_OUT);
  assign results.buoyancy    = buoy;
  assign results.modulus_x   = mod_x;
  assign results.modulus_z   = mod_z;
  assign results.final_point = em_final;
  assign results.unstable    = em_final && (velocity_peak > velocity_limit);

  // A new sample is never taken while a result beat is on offer.
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !results.valid) else $error("sample taken during result");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy) else $error("divider restarted while busy");

  // Instability is only reported on the final result.
  a_unstable_final: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.unstable |-> results.final_point)
    else $error("unstable flag off the final result");

  // After the final result the grid state starts over.
  a_grid_restart: assert property (@(posedge clk) disable iff (rst)
    out_take && results.final_point |=> point_index == '0 && !held_valid)
    else $error("grid state not cleared after final result");

endmodule

// ===== bench/tb_staggered_grid_shear_modulus_prep_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staggered_grid_shear_modulus_prep_unit
// Self-checking bench for the shear modulus preparation block. Grids of
// velocity and density samples go in through a bursty sender. A bit-exact
// predictor of the buoyancy, the harmonic-mean moduli and the stability flag
// fills a queue of expected results. A checker compares every result beat
// against it while the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_staggered_grid_shear_modulus_prep_unit;
  import sgsm_pkg::*;

  localparam logic [MOD_BITS-1:0] MOD_MAX  = '1;
  localparam int                  WDOG_MAX = 5000;
  localparam int                  SETTLE   = 60;
  localparam int                  N_ITEMS  = 1450;

  typedef struct packed {
    logic [BUOY_BITS-1:0] buoyancy;
    logic [MOD_BITS-1:0]  modulus_x;
    logic [MOD_BITS-1:0]  modulus_z;
    logic                 unstable;
    logic                 final_point;
  } point_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  sgsm_sample_if samples();
  sgsm_result_if results();

  staggered_grid_shear_modulus_prep_unit dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state: a copy of the block's registers, held point and row line.
  logic [WIDTH_REG_BITS-1:0] grid_width_q;
  logic [RATIO_BITS-1:0]     step_ratio_q;
  logic [VALUE_BITS-1:0]     velocity_limit_q;
  logic [MOD_BITS-1:0]       row_moduli [0:MAX_WIDTH_DEF-1];
  logic [VALUE_BITS-1:0]     held_vel, held_den, peak_vel;
  logic                      held_ok;
  logic [IDX_BITS-1:0]       raster_idx;

  point_result_t expected_results[$];
  int            mismatches = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  int            quiet_cycles = 0;

  // Floor of 2ab/(a+b), zero when the sum is zero.
  function automatic logic [63:0] harmonic_mean(logic [MOD_BITS-1:0] a,
                                                logic [MOD_BITS-1:0] b);
    logic [127:0] num;
    logic [127:0] sum;
    num = a;
    sum = {86'd0, a} + {86'd0, b};
    if (sum == 0) return 64'd0;
    num = (num * b) << 1;
    return 64'(num / sum);
  endfunction

  // Scale by step_ratio with round-half-up, saturated to the modulus width.
  function automatic logic [MOD_BITS-1:0] scaled_modulus(logic [63:0] hm);
    logic [127:0] p;
    p = hm;
    p = (p * step_ratio_q + (128'd1 << (RATIO_FRAC_BITS - 1))) >> RATIO_FRAC_BITS;
    return (p > MOD_MAX) ? MOD_MAX : p[MOD_BITS-1:0];
  endfunction

  function automatic logic [BUOY_BITS-1:0] buoyancy_for(logic [VALUE_BITS-1:0] den);
    logic [127:0] q;
    if (den == 0) return '1;
    q = {96'd0, step_ratio_q} << BY_SHIFT;
    q = q / den;
    return (q > 128'hFFFF_FFFF) ? '1 : q[BUOY_BITS-1:0];
  endfunction

  function automatic logic [MOD_BITS-1:0] point_modulus(logic [VALUE_BITS-1:0] v,
                                                        logic [VALUE_BITS-1:0] d);
    return MOD_BITS'(v) * MOD_BITS'(v) * MOD_BITS'(d);
  endfunction

  // Emits the result of one point and advances the raster index.
  function automatic void emit_point(logic [VALUE_BITS-1:0] v, logic [VALUE_BITS-1:0] d,
                                     logic [MOD_BITS-1:0] next_m, logic unst, logic fin);
    int                  w;
    int                  col;
    logic [MOD_BITS-1:0] m, up;
    point_result_t       r;
    w = (grid_width_q == 0) ? 1 :
        (grid_width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(grid_width_q);
    m   = point_modulus(v, d);
    col = raster_idx % w;
    up  = (raster_idx >= w) ? row_moduli[col] : m;
    row_moduli[col] = m;
    r.buoyancy    = buoyancy_for(d);
    r.modulus_x   = scaled_modulus(harmonic_mean(m, next_m));
    r.modulus_z   = scaled_modulus(harmonic_mean(m, up));
    r.unstable    = unst;
    r.final_point = fin;
    expected_results.push_back(r);
    raster_idx = raster_idx + 1'b1;
  endfunction

  function automatic void predict_sample(logic [VALUE_BITS-1:0] v,
                                         logic [VALUE_BITS-1:0] d, logic e);
    logic [MOD_BITS-1:0] m_new;
    m_new = point_modulus(v, d);
    if (v > peak_vel) peak_vel = v;
    if (held_ok) emit_point(held_vel, held_den, m_new, 1'b0, 1'b0);
    if (e) begin
      emit_point(v, d, m_new, peak_vel > velocity_limit_q, 1'b1);
      raster_idx = '0;
      held_ok    = 1'b0;
      held_vel   = '0;
      held_den   = '0;
      peak_vel   = '0;
    end else begin
      held_vel = v;
      held_den = d;
      held_ok  = 1'b1;
    end
  endfunction

  // Receiver: runs of ready separated by stalls; some runs carry no stall at all.
  int run_left = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      results.ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      results.ready <= 1'b1;
      run_left--;
    end else begin
      run_left   = $urandom_range(1, 40);
      stall_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 12);
      results.ready <= 1'b1;
    end
  end

  // Result checker: each accepted beat against the oldest expectation.
  always @(posedge clk) begin
    point_result_t exp_r;
    if (!rst && results.valid && results.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, buoyancy %h", $time, results.buoyancy);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (results.buoyancy !== exp_r.buoyancy) begin
          $display("%0t: buoyancy expected %h actual %h", $time,
                   exp_r.buoyancy, results.buoyancy);
          mismatches++;
        end
        if (results.modulus_x !== exp_r.modulus_x) begin
          $display("%0t: modulus_x expected %h actual %h", $time,
                   exp_r.modulus_x, results.modulus_x);
          mismatches++;
        end
        if (results.modulus_z !== exp_r.modulus_z) begin
          $display("%0t: modulus_z expected %h actual %h", $time,
                   exp_r.modulus_z, results.modulus_z);
          mismatches++;
        end
        if (results.unstable !== exp_r.unstable) begin
          $display("%0t: unstable expected %b actual %b", $time,
                   exp_r.unstable, results.unstable);
          mismatches++;
        end
        if (results.final_point !== exp_r.final_point) begin
          $display("%0t: final_point expected %b actual %b", $time,
                   exp_r.final_point, results.final_point);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a run of cycles with no beat on either channel ends the test.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Register write in setup and access phases; the predictor copy follows on the access edge.
  // The bus then goes idle so that writes never overlap.
  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:     grid_width_q     = value[WIDTH_REG_BITS-1:0];
      REG_STEP_RATIO:     step_ratio_q     = value;
      REG_VELOCITY_LIMIT: velocity_limit_q = value[VALUE_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One sample beat. valid stays high on return so a following beat can go
  // back to back; anything else that follows lowers it first.
  task automatic send_sample(logic [VALUE_BITS-1:0] v, logic [VALUE_BITS-1:0] d,
                             logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        samples.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    samples.valid          <= 1'b1;
    samples.shear_velocity <= v;
    samples.density        <= d;
    samples.grid_end       <= e;
    do @(posedge clk); while (!samples.ready);
    predict_sample(v, d, e);
    items_sent++;
  endtask

  // Sender pause until every expected result has been taken. With nothing
  // outstanding no time passes, so the next beat replaces the last one at once.
  task automatic wait_drained();
    if (expected_results.size() != 0) begin
      samples.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk);
    end
  endtask

  // Idle point for register writes: drained, plus room for a beat that
  // causes no result but is still forming its modulus.
  task automatic settle();
    samples.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] w, logic [31:0] ratio, logic [31:0] limit);
    settle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_STEP_RATIO, ratio);
    write_reg(REG_VELOCITY_LIMIT, limit);
  endtask

  // Extremes of every field, zero density, zero-sum means, a lone grid-end
  // point, width clamping, an unknown register and a mid-grid drain.
  task automatic test_directed();
    configure(3, 32'hFFFF_FFFF, 100);
    send_sample(0, 1, 0);
    send_sample(16383, 16383, 0);
    send_sample(16383, 0, 0);
    send_sample(1, 1, 0);
    wait_drained();
    send_sample(100, 16383, 0);
    send_sample(8191, 8192, 0);
    send_sample(0, 0, 0);
    send_sample(5, 5, 0);
    send_sample(16383, 1, 1);
    send_sample(7, 7, 1);
    configure(0, 0, 16383);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_sample(16383, 16383, 0);
    send_sample(3, 3, 1);
    configure(16383, 32'h0001_0000, 0);
    send_sample(0, 0, 0);
    send_sample(0, 16383, 0);
    send_sample(1, 16383, 1);
    configure(1024, 32'h8000_0001, 16383);
    send_sample(12345, 6789, 0);
    send_sample(16383, 16383, 1);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value(int lo);
    case ($urandom % 6)
      0:       return VALUE_BITS'(lo);
      1:       return '1;
      2:       return VALUE_BITS'($urandom_range(lo, 63));
      default: return VALUE_BITS'($urandom_range(lo, 16383));
    endcase
  endfunction

  // Whole grids of random content under a fresh setting now and then.
  task automatic test_random_grids();
    int          len, w, lim;
    logic [31:0] ratio;
    while (items_sent < N_ITEMS) begin
      if ($urandom % 3 == 0) begin
        case ($urandom % 10)
          0:       w = 0;
          1:       w = $urandom_range(1025, 16383);
          2:       w = $urandom_range(65, 1024);
          default: w = $urandom_range(1, 12);
        endcase
        case ($urandom % 5)
          0:       ratio = 0;
          1:       ratio = '1;
          default: ratio = $urandom;
        endcase
        lim = ($urandom % 3 == 0) ? 16383 : $urandom_range(0, 16383);
        configure(w, ratio, lim);
      end
      w = (grid_width_q == 0) ? 1 :
          (grid_width_q > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(grid_width_q);
      len = (w > 12) ? $urandom_range(1, 30) : $urandom_range(1, 3 * w + 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom % 60 == 0) wait_drained();
        send_sample(pick_value(0), pick_value(1), i == len - 1);
      end
      // Grids always end before a register write, so the width never changes
      // mid-grid and no unwritten row entry is read.
    end
  endtask

  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    samples.valid  <= 1'b0;
    samples.shear_velocity <= '0;
    samples.density        <= '0;
    samples.grid_end       <= 1'b0;
    grid_width_q     = 1;
    step_ratio_q     = 0;
    velocity_limit_q = '1;
    held_ok    = 1'b0;
    held_vel   = '0;
    held_den   = '0;
    peak_vel   = '0;
    raster_idx = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_grids();

    settle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sgsm_pkg.sv
sv/sgsm_sample_if.sv
sv/sgsm_result_if.sv
sv/sgsm_mul.sv
sv/sgsm_div.sv
sv/staggered_grid_shear_modulus_prep_unit.sv
bench/tb_staggered_grid_shear_modulus_prep_unit.sv
